@@ src/ille_pkg.sv @@
package ille_pkg;

   localparam int POS_W = 9;
   localparam int VAL_W = 32;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_SPARE = 2'd3
   } status_type;

   typedef struct packed {
      mode_type                 mode;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]  read_value;
      status_type               status;
      logic [POS_W-1:0]         length;
   } rsp_type;

endpackage

@@ src/indexed_linked_list_engine.sv @@
// Ordered list of up to CAPACITY signed 32-bit values, kept as a singly linked
// list in two synchronous slot memories (values and links) with a chain of free
// slots. One request at a time: insert at position 0..length, delete at a
// position, or read at a position; each gives exactly one response with the
// read value, a status (done, position out of range, list full) and the new
// length. An item's time in the block grows with its position: it is set by the
// walk along the link chain, one slot per cycle through the single read port
// of the link memory. Reading the last entry or touching the head needs no
// walk, and rejected requests go straight from the decision to the response.
// Every response is registered as the block returns to idle. A response still
// stalled from the previous item holds the block until its register is free.
// No clearing pass after reset: slots never handed out are tracked by a fill
// count, so the block is ready at once. A new request is taken while the
// previous response still waits in its register.
module indexed_linked_list_engine #(
   parameter int CAPACITY = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ille_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ille_pkg::rsp_type rsp_data
);
   import ille_pkg::*;

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [11:0] {
      S_IDLE       = 12'b000000000001,
      S_DECIDE     = 12'b000000000010,
      S_WALK       = 12'b000000000100,
      S_INS_ALLOC  = 12'b000000001000,
      S_INS_TAIL   = 12'b000000010000,
      S_INS_LINK   = 12'b000000100000,
      S_INS_SPLICE = 12'b000001000000,
      S_DEL_FIND   = 12'b000010000000,
      S_DEL_NEXT   = 12'b000100000000,
      S_DEL_FREE   = 12'b001000000000,
      S_RD_GET     = 12'b010000000000,
      S_FINISH     = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   req_type                op_ff, op_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [CW-1:0]          fresh_ff, fresh_in;
   logic [SW-1:0]          first_ff, first_in;
   logic [SW-1:0]          last_ff, last_in;
   logic [SW-1:0]          free_ff, free_in;
   logic [SW-1:0]          slot_a_ff, slot_a_in;
   logic [SW-1:0]          slot_b_ff, slot_b_in;
   logic [PW-1:0]          remain_ff, remain_in;
   logic                   walk_live_ff, walk_live_in;
   logic signed [VAL_W-1:0] res_value_ff, res_value_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   // slot memories
   logic [SW-1:0]    link_mem [CAPACITY];
   logic [VAL_W-1:0] val_mem  [CAPACITY];
   logic [SW-1:0]    link_rdata;
   logic [VAL_W-1:0] val_rdata;
   logic             link_re, link_we, val_re, val_we;
   logic [SW-1:0]    link_raddr, link_waddr, link_wdata, val_raddr;

   logic [PW-1:0] pos_x, cnt_x;
   logic [SW-1:0] cur_slot, next_fresh;

   assign pos_x     = PW'(op_ff.position);
   assign cnt_x     = PW'(cnt_ff);
   assign cur_slot  = walk_live_ff ? link_rdata : first_ff;
   assign next_fresh = (slot_a_ff == SW'(CAPACITY - 1)) ? '0 : slot_a_ff + 1'b1;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // link memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rdata <= link_mem[link_raddr];
      end
   end

   // value memory
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[slot_a_ff] <= op_ff.value;
      end
      if (val_re) begin
         val_rdata <= val_mem[val_raddr];
      end
   end

   // sequence one operation; reads and writes never hit one entry in one cycle
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      fresh_in      = fresh_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      free_in       = free_ff;
      slot_a_in     = slot_a_ff;
      slot_b_in     = slot_b_ff;
      remain_in     = remain_ff;
      walk_live_in  = walk_live_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      link_re       = 1'b0;
      link_raddr    = '0;
      link_we       = 1'b0;
      link_waddr    = '0;
      link_wdata    = '0;
      val_re        = 1'b0;
      val_raddr     = '0;
      val_we        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_value_in  = '0;
            res_status_in = STATUS_DONE;
            state_in      = S_FINISH;
            unique case (op_ff.mode)
               MODE_INSERT: begin
                  if (pos_x > cnt_x) begin
                     res_status_in = STATUS_RANGE;
                  end else if (cnt_x == PW'(CAPACITY)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     link_re    = 1'b1;
                     link_raddr = free_ff;
                     slot_a_in  = free_ff;
                     state_in   = S_INS_ALLOC;
                  end
               end
               MODE_DELETE: begin
                  if (pos_x >= cnt_x) begin
                     res_status_in = STATUS_RANGE;
                  end else if (pos_x == '0) begin
                     link_re    = 1'b1;
                     link_raddr = first_ff;
                     slot_a_in  = first_ff;
                     state_in   = S_DEL_NEXT;
                  end else begin
                     remain_in    = pos_x - 1'b1;
                     walk_live_in = 1'b0;
                     state_in     = S_WALK;
                  end
               end
               MODE_READ: begin
                  if (pos_x >= cnt_x) begin
                     res_status_in = STATUS_RANGE;
                  end else if (pos_x == cnt_x - 1'b1) begin
                     val_re    = 1'b1;
                     val_raddr = last_ff;
                     state_in  = S_RD_GET;
                  end else begin
                     remain_in    = pos_x;
                     walk_live_in = 1'b0;
                     state_in     = S_WALK;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_INS_ALLOC: begin
            // take the free slot; a never-used slot chains to the next one
            if (fresh_ff == CW'(slot_a_ff)) begin
               free_in  = next_fresh;
               fresh_in = fresh_ff + 1'b1;
            end else begin
               free_in = link_rdata;
            end
            val_we = 1'b1;
            if (pos_x == '0) begin
               link_we    = 1'b1;
               link_waddr = slot_a_ff;
               link_wdata = first_ff;
               first_in   = slot_a_ff;
               if (cnt_ff == '0) begin
                  last_in = slot_a_ff;
               end
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_FINISH;
            end else if (pos_x == cnt_x) begin
               link_we    = 1'b1;
               link_waddr = slot_a_ff;
               link_wdata = '0;
               state_in   = S_INS_TAIL;
            end else begin
               remain_in    = pos_x - 1'b1;
               walk_live_in = 1'b0;
               state_in     = S_WALK;
            end
         end
         S_INS_TAIL: begin
            link_we    = 1'b1;
            link_waddr = last_ff;
            link_wdata = slot_a_ff;
            last_in    = slot_a_ff;
            cnt_in     = cnt_ff + 1'b1;
            state_in   = S_FINISH;
         end
         S_WALK: begin
            // advance one link per cycle straight from the read data
            if (remain_ff == '0) begin
               slot_b_in = cur_slot;
               if (op_ff.mode == MODE_READ) begin
                  val_re    = 1'b1;
                  val_raddr = cur_slot;
                  state_in  = S_RD_GET;
               end else begin
                  link_re    = 1'b1;
                  link_raddr = cur_slot;
                  state_in   = (op_ff.mode == MODE_INSERT) ? S_INS_LINK : S_DEL_FIND;
               end
            end else begin
               link_re      = 1'b1;
               link_raddr   = cur_slot;
               remain_in    = remain_ff - 1'b1;
               walk_live_in = 1'b1;
            end
         end
         S_INS_LINK: begin
            link_we    = 1'b1;
            link_waddr = slot_a_ff;
            link_wdata = link_rdata;
            state_in   = S_INS_SPLICE;
         end
         S_INS_SPLICE: begin
            link_we    = 1'b1;
            link_waddr = slot_b_ff;
            link_wdata = slot_a_ff;
            cnt_in     = cnt_ff + 1'b1;
            state_in   = S_FINISH;
         end
         S_DEL_FIND: begin
            slot_a_in  = link_rdata;
            link_re    = 1'b1;
            link_raddr = link_rdata;
            if (pos_x == cnt_x - 1'b1) begin
               last_in = slot_b_ff;
            end
            state_in = S_DEL_NEXT;
         end
         S_DEL_NEXT: begin
            // unlink the entry from its predecessor or from the head
            if (pos_x == '0) begin
               first_in = link_rdata;
            end else begin
               link_we    = 1'b1;
               link_waddr = slot_b_ff;
               link_wdata = link_rdata;
            end
            state_in = S_DEL_FREE;
         end
         S_DEL_FREE: begin
            link_we    = 1'b1;
            link_waddr = slot_a_ff;
            link_wdata = free_ff;
            free_in    = slot_a_ff;
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               first_in = '0;
               last_in  = '0;
            end
            state_in = S_FINISH;
         end
         S_RD_GET: begin
            res_value_in = val_rdata;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.read_value = res_value_ff;
               rsp_in.status     = res_status_ff;
               rsp_in.length     = cnt_x[POS_W-1:0];
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         fresh_ff     <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fresh_ff     <= fresh_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_a_ff     <= slot_a_in;
      slot_b_ff     <= slot_b_in;
      remain_ff     <= remain_in;
      walk_live_ff  <= walk_live_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CW'(CAPACITY)) && (fresh_ff <= CW'(CAPACITY)))
      else $error("entry or fill count beyond capacity");

   a_ins_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_SPLICE || state_ff == S_INS_TAIL)
      |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("insert did not grow the list by one");

   a_del_shrink: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEL_FREE |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("delete did not shrink the list by one");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && res_status_ff == STATUS_FULL) |-> cnt_x == PW'(CAPACITY))
      else $error("full reported on a list with room");

   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && remain_ff == '0) |=> state_ff != S_WALK)
      else $error("link walk ran past its target");

endmodule
